@@ rtl/wpm_pkg.sv @@
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

   localparam int CHAR_W       = 8;
   localparam int WORD_W       = 64;
   localparam int WORD_COUNT   = 4;
   localparam int CHARS_STORED = WORD_COUNT * WORD_W / CHAR_W;
   localparam int LEN_REG_W    = 6;
   localparam int COUNT_W      = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int RSP_DATA_W   = 8;

   localparam logic [CHAR_W-1:0] STAR_CHAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] ANY_CHAR    = 8'h3F;
   localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   // bit positions in rsp_tdata
   localparam int RSP_MATCHED_BIT  = 0;
   localparam int RSP_ACCEPTED_BIT = 1;
   localparam int RSP_FULL_BIT     = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_WORD0   = 3'd0,
      CSR_PAT_WORD1   = 3'd1,
      CSR_PAT_WORD2   = 3'd2,
      CSR_PAT_WORD3   = 3'd3,
      CSR_PAT_LENGTH  = 3'd4,
      CSR_CASE_SENS   = 3'd5,
      CSR_MAX_MATCHES = 3'd6
   } csr_index_type;

endpackage : wpm_pkg

`default_nettype wire

@@ rtl/wildcard_pattern_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit
// Streaming glob matcher: '*' any run, '?' any one character, optional case
// folding, with a bounded count of accepted matches.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  req_     | in  | tdata = text_char, tuser = char_present, tlast = end_of_string
//  rsp_     | out | tdata = matched, accepted, list_full (bits 0..2)
//  csr_     | in  | index 0..6, 64-bit write data, always ready
//
//  One request per cycle while no end-of-string request waits on a stalled
//  result. A request is held in the input register, then updates the position
//  set and, at end of string, loads the result register that drives rsp_tvalid.
//  Reset is synchronous; it clears the configuration, both valid flags, the
//  position set to position zero and the match count. A stalled result stops only end-of-string requests.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher_unit
   import wpm_pkg::*;
#(
   parameter int PATTERN_MAX = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [CHAR_W-1:0]      req_tdata,   // [7:0] text_char
   input  wire logic                   req_tuser,   // [0] char_present
   input  wire logic                   req_tlast,   // end_of_string
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [0] matched, [1] accepted,
                                                    // [2] list_full, rest zero
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_wdata
);

   localparam int CAP   = (PATTERN_MAX < CHARS_STORED) ? PATTERN_MAX : CHARS_STORED;
   localparam int W     = CAP + 1;
   localparam int LEN_W = $clog2(W);
   localparam int LVLS  = $clog2(W);

   // closure: a set bit on a '*' position also sets the next position
   function automatic logic [W-1:0] star_close(input logic [W-1:0] set_in,
                                                input logic [W-1:0] star_in);
      logic [W-1:0] x;
      logic [W-1:0] p;
      x = set_in;
      p = star_in;
      for (int lv = 0; lv < LVLS; lv++) begin
         x = x | ((x & p) << (1 << lv));
         p = p & (p >> (1 << lv));
      end
      return x;
   endfunction

   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                              input logic cs);
      logic [CHAR_W-1:0] r;
      r = c;
      if (!cs && c >= LOWER_A && c <= LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   // configuration
   logic [WORD_COUNT-1:0][WORD_W-1:0] pat_ff;
   logic [LEN_REG_W-1:0]              len_ff;
   logic                              cs_ff;
   logic [COUNT_W-1:0]                max_ff;

   // input register
   logic              in_vld_ff, in_vld_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_present_ff;
   logic              in_end_ff;

   // state
   logic [W-1:0]       active_ff, active_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // result register
   logic       rsp_vld_ff, rsp_vld_in;
   logic [2:0] rsp_data_ff, rsp_data_in;

   logic              req_take, out_free, advance;
   logic [LEN_W-1:0]  len_eff;
   logic [CHAR_W-1:0] pat_chars [CAP];
   logic [W-1:0]      star_mask, hit_mask;
   logic [W-1:0]      cur_set, next_set, fin_set;
   logic [CHAR_W-1:0] text_fold;
   logic              matched, full, acc;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && (!in_end_ff || out_free);
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-3){1'b0}}, rsp_data_ff};

   always_comb begin
      if (len_ff > LEN_REG_W'(CAP)) begin
         len_eff = LEN_W'(CAP);
      end else begin
         len_eff = len_ff[LEN_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         pat_chars[i] = pat_ff[i >> 3][((i & 7) << 3) +: CHAR_W];
      end
   end

   assign text_fold = fold(in_char_ff, cs_ff);

   always_comb begin
      star_mask = '0;
      hit_mask  = '0;
      for (int i = 0; i < CAP; i++) begin
         if (LEN_W'(i) < len_eff) begin
            star_mask[i] = (pat_chars[i] == STAR_CHAR);
            hit_mask[i]  = (pat_chars[i] != STAR_CHAR)
                           && ((pat_chars[i] == ANY_CHAR)
                               || (fold(pat_chars[i], cs_ff) == text_fold));
         end
      end
   end

   always_comb begin
      cur_set  = star_close(active_ff, star_mask);
      next_set = (cur_set & star_mask) | ((cur_set & hit_mask) << 1);
      fin_set  = star_close(in_present_ff ? next_set : active_ff, star_mask);
      matched  = fin_set[len_eff];
      full     = (count_ff >= max_ff);
      acc      = matched && !full;
   end

   always_comb begin
      in_vld_in   = in_vld_ff;
      active_in   = active_ff;
      count_in    = count_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         in_vld_in = 1'b0;
         if (in_end_ff) begin
            active_in   = W'(1);
            rsp_vld_in  = 1'b1;
            rsp_data_in = '0;
            rsp_data_in[RSP_MATCHED_BIT]  = matched;
            rsp_data_in[RSP_ACCEPTED_BIT] = acc;
            rsp_data_in[RSP_FULL_BIT]     = full;
            if (acc) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else if (in_present_ff) begin
            active_in = next_set;
         end
      end
      if (req_take) begin
         in_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         active_ff  <= W'(1);
         count_ff   <= '0;
         pat_ff     <= '0;
         len_ff     <= '0;
         cs_ff      <= 1'b0;
         max_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         active_ff  <= active_in;
         count_ff   <= count_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_PAT_WORD0:   pat_ff[0] <= csr_wdata;
               CSR_PAT_WORD1:   pat_ff[1] <= csr_wdata;
               CSR_PAT_WORD2:   pat_ff[2] <= csr_wdata;
               CSR_PAT_WORD3:   pat_ff[3] <= csr_wdata;
               CSR_PAT_LENGTH:  len_ff    <= csr_wdata[LEN_REG_W-1:0];
               CSR_CASE_SENS:   cs_ff     <= csr_wdata[0];
               CSR_MAX_MATCHES: max_ff    <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff    <= req_tdata;
         in_present_ff <= req_tuser;
         in_end_ff     <= req_tlast;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule : wildcard_pattern_matcher_unit

`default_nettype wire

@@ rtl/wpm_checker.sv @@
// ----------------------------------------------------------------------------
// wpm_checker
// Port-level checks for the wildcard pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_checker
   import wpm_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   a_acc_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_ACCEPTED_BIT] |-> rsp_tdata[RSP_MATCHED_BIT])
      else $error("accepted without match");

   a_acc_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_ACCEPTED_BIT] |-> !rsp_tdata[RSP_FULL_BIT])
      else $error("accepted while full");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result pending after reset");

endmodule : wpm_checker

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (.*);

`default_nettype wire
